FILE: hdl/wol_pkg.sv
// shared types and constants of the wavetable oscillator
package wol_pkg;

    // input command codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP  = 2'd2;

    // configuration register indexes
    localparam logic REG_TABLE_LENGTH = 1'b0;
    localparam logic REG_SAMPLE_RATE  = 1'b1;

    // field widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int WADDR_W  = 10;
    localparam int WVAL_W   = 16;
    localparam int FREQ_W   = 24;
    localparam int PHASE_W  = 32;
    localparam int TLEN_W   = 11;
    localparam int RATE_W   = 18;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // reset values of the configuration registers
    localparam logic [TLEN_W-1:0] TLEN_RESET = 11'd1024;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    // phase increment divider: dividend is the magnitude shifted up by 24
    localparam int FREQ_SHIFT = 24;
    localparam int DIV_STEPS  = FREQ_W + FREQ_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // classified operation
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_ADVANCE,
        OP_LOOKUP
    } op_t;

    // one classified item as it travels through the queue
    typedef struct packed {
        op_t                 op;
        logic                neg;
        logic [WADDR_W-1:0]  addr;
        logic [WVAL_W-1:0]   value;
        logic [PHASE_W-1:0]  arg;
    } item_t;

    // back end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_ADDR,
        ST_RD_B,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } back_state_t;

endpackage

FILE: hdl/wol_front.sv
// front end: accepts input items and classifies them for the back end
module wol_front #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           push,
    output logic                           full,
    input  logic [wol_pkg::CMD_W-1:0]      cmd,
    input  logic [wol_pkg::WADDR_W-1:0]    write_address,
    input  logic signed [wol_pkg::WVAL_W-1:0] write_value,
    input  logic signed [wol_pkg::FREQ_W-1:0] frequency,
    input  logic signed [wol_pkg::PHASE_W-1:0] at_phase,
    input  logic                           q_full,
    output logic                           q_push,
    output wol_pkg::item_t                 q_item
);

    logic keep;

    assign full = q_full;

    // classify the command and prepare its operands
    always_comb
    begin
        keep          = 1'b0;
        q_item.op     = wol_pkg::OP_WRITE;
        q_item.neg    = frequency[wol_pkg::FREQ_W-1];
        q_item.addr   = write_address;
        q_item.value  = write_value;
        q_item.arg    = '0;
        case (cmd)
            wol_pkg::CMD_WRITE:
            begin
                // writes beyond the table are dropped here
                keep      = (32'(write_address) < 32'(TABLE_DEPTH));
                q_item.op = wol_pkg::OP_WRITE;
            end
            wol_pkg::CMD_ADVANCE:
            begin
                // magnitude of the frequency, sign kept apart
                keep      = 1'b1;
                q_item.op = wol_pkg::OP_ADVANCE;
                if (frequency[wol_pkg::FREQ_W-1])
                begin
                    q_item.arg = 32'(~frequency + 24'sd1);
                end
                else
                begin
                    q_item.arg = 32'(frequency);
                end
            end
            wol_pkg::CMD_LOOKUP:
            begin
                // negative phase reads at zero, whole cycles drop out
                keep      = 1'b1;
                q_item.op = wol_pkg::OP_LOOKUP;
                if (!at_phase[wol_pkg::PHASE_W-1])
                begin
                    q_item.arg = {at_phase[23:0], 8'h00};
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = push && !q_full && keep;

endmodule

FILE: hdl/wol_queue.sv
// two-entry queue decoupling the front end from the back end
module wol_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wol_pkg::item_t item_in,
    output logic           full,
    input  logic           pop,
    output wol_pkg::item_t item_out,
    output logic           empty
);

    wol_pkg::item_t                      entry_reg [wol_pkg::QUEUE_DEPTH];
    logic [wol_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [wol_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [wol_pkg::QUEUE_CNT_W-1:0]     count_reg, count_next;
    logic                                do_push, do_pop;

    assign full     = (count_reg == wol_pkg::QUEUE_CNT_W'(wol_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

FILE: hdl/wol_div.sv
// restoring divider for the phase increment, one quotient bit per cycle
module wol_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [wol_pkg::FREQ_W-1:0]    mag,
    input  logic [wol_pkg::RATE_W-1:0]    divisor,
    output logic                          busy,
    output logic [wol_pkg::PHASE_W-1:0]   quotient
);

    logic                                 busy_reg, busy_next;
    logic [wol_pkg::DIV_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [wol_pkg::RATE_W-1:0]           rem_reg, rem_next;
    logic [wol_pkg::DIV_STEPS-1:0]        quo_reg, quo_next;
    logic [wol_pkg::RATE_W-1:0]           dvs_reg, dvs_next;
    logic [wol_pkg::RATE_W:0]             trial;

    assign busy     = busy_reg;
    assign quotient = quo_reg[wol_pkg::PHASE_W-1:0];
    assign trial    = {rem_reg, quo_reg[wol_pkg::DIV_STEPS-1]};

    // one shift and trial subtract per cycle
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = {mag, {wol_pkg::FREQ_SHIFT{1'b0}}};
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = wol_pkg::RATE_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[wol_pkg::DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[wol_pkg::RATE_W-1:0];
                quo_next = {quo_reg[wol_pkg::DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == wol_pkg::DIV_CNT_W'(wol_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

FILE: hdl/wol_back.sv
// back end: table memory, phase accumulator and interpolation sequencer
module wol_back #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [wol_pkg::TLEN_W-1:0]        table_length,
    input  logic [wol_pkg::RATE_W-1:0]        sample_rate,
    input  wol_pkg::item_t                    q_item,
    input  logic                              q_empty,
    output logic                              q_pop,
    output logic                              div_start,
    output logic [wol_pkg::FREQ_W-1:0]        div_mag,
    input  logic                              div_busy,
    input  logic [wol_pkg::PHASE_W-1:0]       div_quotient,
    output logic signed [SAMPLE_BITS-1:0]     sample,
    output logic                              empty,
    input  logic                              pop
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W  = wol_pkg::PHASE_W + LEN_W;
    localparam int PROD_W = SAMPLE_BITS + 18;

    wol_pkg::back_state_t               state_reg, state_next;

    logic [SAMPLE_BITS-1:0]             mem [TABLE_DEPTH];
    logic [SAMPLE_BITS-1:0]             rd_data_reg;
    logic [IDX_W-1:0]                   rd_addr;
    logic                               mem_we;

    logic [wol_pkg::PHASE_W-1:0]        phase_reg, phase_next;
    logic [wol_pkg::PHASE_W-1:0]        frac_reg;
    logic                               is_adv_reg;
    logic                               neg_reg;
    logic [POS_W-1:0]                   pos_reg;
    logic [IDX_W-1:0]                   i2_reg;
    logic [SAMPLE_BITS-1:0]             a_reg;
    logic [SAMPLE_BITS:0]               diff_reg;
    logic [PROD_W-1:0]                  prod_reg;
    logic [SAMPLE_BITS-1:0]             res_reg;
    logic                               out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]             sample_reg;

    logic [LEN_W-1:0]                   n_eff;
    logic [IDX_W-1:0]                   i1;
    logic [31:0]                        i1_inc;
    logic [IDX_W-1:0]                   i2;
    logic [wol_pkg::PHASE_W-1:0]        inc;
    logic                               out_load;
    logic signed [PROD_W-1:0]           diff_ext;
    logic signed [PROD_W-1:0]           f_ext;
    logic [SAMPLE_BITS+1:0]             sum;

    assign div_mag = q_item.arg[wol_pkg::FREQ_W-1:0];
    assign sample  = sample_reg;
    assign empty   = !out_valid_reg;

    // table length in use: zero reads as one, clipped at the table depth
    always_comb
    begin
        if (table_length == '0)
        begin
            n_eff = LEN_W'(1);
        end
        else if (32'(table_length) > 32'(TABLE_DEPTH))
        begin
            n_eff = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = LEN_W'(table_length);
        end
    end

    // neighbouring indexes, the one after the last wraps to entry zero
    assign i1     = pos_reg[wol_pkg::PHASE_W +: IDX_W];
    assign i1_inc = 32'(i1) + 32'd1;
    assign i2     = (i1_inc >= 32'(n_eff)) ? '0 : IDX_W'(i1_inc);

    // signed phase increment, zero sample rate leaves the phase alone
    always_comb
    begin
        if (sample_rate == '0)
        begin
            inc = '0;
        end
        else if (neg_reg)
        begin
            inc = ~div_quotient + 32'd1;
        end
        else
        begin
            inc = div_quotient;
        end
    end

    // interpolation operands
    assign diff_ext = PROD_W'(signed'(diff_reg));
    assign f_ext    = signed'(PROD_W'(pos_reg[31:16]));
    assign sum      = {{2{a_reg[SAMPLE_BITS-1]}}, a_reg} + prod_reg[PROD_W-1:16];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wol_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_item.op)
                        wol_pkg::OP_ADVANCE: state_next = wol_pkg::ST_POS;
                        wol_pkg::OP_LOOKUP:  state_next = wol_pkg::ST_POS;
                        default:             state_next = wol_pkg::ST_IDLE;
                    endcase
                end
            end
            wol_pkg::ST_POS:  state_next = wol_pkg::ST_ADDR;
            wol_pkg::ST_ADDR: state_next = wol_pkg::ST_RD_B;
            wol_pkg::ST_RD_B: state_next = wol_pkg::ST_DIFF;
            wol_pkg::ST_DIFF: state_next = wol_pkg::ST_MUL;
            wol_pkg::ST_MUL:  state_next = wol_pkg::ST_SUM;
            wol_pkg::ST_SUM:  state_next = wol_pkg::ST_DONE;
            wol_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = wol_pkg::ST_IDLE;
                end
            end
            default: state_next = wol_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        rd_addr   = i1;
        out_load  = 1'b0;
        case (state_reg)
            wol_pkg::ST_IDLE:
            begin
                q_pop     = !q_empty;
                mem_we    = !q_empty && (q_item.op == wol_pkg::OP_WRITE);
                div_start = !q_empty && (q_item.op == wol_pkg::OP_ADVANCE);
            end
            wol_pkg::ST_ADDR: rd_addr = i1;
            wol_pkg::ST_RD_B: rd_addr = i2_reg;
            wol_pkg::ST_DONE:
            begin
                out_load = (!out_valid_reg || pop) && !(is_adv_reg && div_busy);
            end
            default:
            begin
                rd_addr = i1;
            end
        endcase
    end

    // result register and phase accumulator
    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (is_adv_reg)
            begin
                phase_next = phase_reg + inc;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wol_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // interpolation datapath, one step per state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            wol_pkg::ST_IDLE:
            begin
                is_adv_reg <= (q_item.op == wol_pkg::OP_ADVANCE);
                neg_reg    <= q_item.neg;
                if (q_item.op == wol_pkg::OP_ADVANCE)
                begin
                    frac_reg <= phase_reg;
                end
                else
                begin
                    frac_reg <= q_item.arg;
                end
            end
            wol_pkg::ST_POS:  pos_reg  <= POS_W'(frac_reg) * POS_W'(n_eff);
            wol_pkg::ST_ADDR: i2_reg   <= i2;
            wol_pkg::ST_RD_B: a_reg    <= rd_data_reg;
            wol_pkg::ST_DIFF:
            begin
                diff_reg <= {rd_data_reg[SAMPLE_BITS-1], rd_data_reg}
                            - {a_reg[SAMPLE_BITS-1], a_reg};
            end
            wol_pkg::ST_MUL:  prod_reg <= PROD_W'(diff_ext * f_ext);
            wol_pkg::ST_SUM:  res_reg  <= sum[SAMPLE_BITS-1:0];
            default:
            begin
                res_reg <= res_reg;
            end
        endcase
        if (out_load)
        begin
            sample_reg <= res_reg;
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[IDX_W'(q_item.addr)] <= SAMPLE_BITS'(signed'(q_item.value));
        end
        rd_data_reg <= mem[rd_addr];
    end

    // the queue is only drained when it holds an item
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // a started division is seen busy by the next cycle
    a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");

    // a waiting result is never overwritten
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(sample_reg))
        else $error("waiting result overwritten");

    // the phase moves only when an advance completes
    a_phase_move: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg)) |-> $past(out_load && is_adv_reg))
        else $error("phase changed outside an advance");

endmodule

FILE: hdl/wavetable_oscillator_lerp_unit.sv
// top level of the wavetable oscillator with linear interpolation
//
// Input items enter through a queue-style port (push, full) and results leave
// through another (empty, pop). Table writes give no result; advance and
// lookup items each give one interpolated sample, in order.
// A front end classifies each item and drops unused commands and writes
// beyond the table; a two-entry queue hands items to the back end.
// Back end steps: a table write is done as it leaves the queue. A lookup
// runs through position multiply, two registered table reads, difference,
// fraction multiply, sum and result load. An advance runs the same steps,
// and its result load also waits for the restoring divider that forms the
// phase increment one bit per cycle, running alongside the interpolation.
// A single output register holds the oldest result; while the receiver does
// not pop, the back end waits at its last step and the queue fills, then
// full rises. Reset clears the phase accumulator, the item queue and the
// result register and sets table_length to 1024 and sample_rate to 48000;
// the table holds nothing valid until written. Configuration is written
// over the APB-style port.
module wavetable_oscillator_lerp_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item channel
    input  logic                                  push,
    output logic                                  full,
    input  logic [wol_pkg::CMD_W-1:0]             cmd,
    input  logic [wol_pkg::WADDR_W-1:0]           write_address,
    input  logic signed [wol_pkg::WVAL_W-1:0]     write_value,
    input  logic signed [wol_pkg::FREQ_W-1:0]     frequency,
    input  logic signed [wol_pkg::PHASE_W-1:0]    at_phase,
    // result channel
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [SAMPLE_BITS-1:0]         sample,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wol_pkg::APB_AW-1:0]            paddr,
    input  logic [wol_pkg::APB_DW-1:0]            pwdata,
    output logic [wol_pkg::APB_DW-1:0]            prdata,
    output logic                                  pready
);

    logic [wol_pkg::TLEN_W-1:0]       table_length_reg, table_length_next;
    logic [wol_pkg::RATE_W-1:0]       sample_rate_reg, sample_rate_next;
    logic                             cfg_wr;
    logic                             cfg_index;

    logic                             q_push, q_full, q_pop, q_empty;
    wol_pkg::item_t                   q_in, q_out;

    logic                             div_start, div_busy;
    logic [wol_pkg::FREQ_W-1:0]       div_mag;
    logic [wol_pkg::PHASE_W-1:0]      div_quotient;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];

    always_comb
    begin
        table_length_next = table_length_reg;
        sample_rate_next  = sample_rate_reg;
        if (cfg_wr)
        begin
            case (cfg_index)
                wol_pkg::REG_TABLE_LENGTH:
                    table_length_next = pwdata[wol_pkg::TLEN_W-1:0];
                wol_pkg::REG_SAMPLE_RATE:
                    sample_rate_next  = pwdata[wol_pkg::RATE_W-1:0];
                default:
                    table_length_next = table_length_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (cfg_index)
            wol_pkg::REG_TABLE_LENGTH: prdata = wol_pkg::APB_DW'(table_length_reg);
            wol_pkg::REG_SAMPLE_RATE:  prdata = wol_pkg::APB_DW'(sample_rate_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= wol_pkg::TLEN_RESET;
            sample_rate_reg  <= wol_pkg::RATE_RESET;
        end
        else
        begin
            table_length_reg <= table_length_next;
            sample_rate_reg  <= sample_rate_next;
        end
    end

    // item classification
    wol_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .write_address (write_address),
        .write_value   (write_value),
        .frequency     (frequency),
        .at_phase      (at_phase),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    // decoupling queue
    wol_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_out),
        .empty    (q_empty)
    );

    // phase increment divider
    wol_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (div_mag),
        .divisor  (sample_rate_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // table, accumulator and interpolation
    wol_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_length (table_length_reg),
        .sample_rate  (sample_rate_reg),
        .q_item       (q_out),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_mag      (div_mag),
        .div_busy     (div_busy),
        .div_quotient (div_quotient),
        .sample       (sample),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
